/* rtl/core/slcs_pkg.sv */
`timescale 1ns / 1ps

package slcs_pkg;

	// default width of the wrapping time arithmetic
	localparam int DEF_TIME_BITS = 32;

	localparam int IN_TIME_W  = 32;
	localparam int TXN_W      = 32;
	localparam int PERIOD_W   = 16;
	localparam int BRIGHT_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CYC_LEN_W  = 3;
	localparam int CYC_POS_W  = 2;

	// register defaults after reset
	localparam logic [PERIOD_W-1:0] FAST_BLINK_RST  = 16'd125;
	localparam logic [PERIOD_W-1:0] STATUS_STEP_RST = 16'd500;
	localparam logic [PERIOD_W-1:0] BUS_TIMEOUT_RST = 16'd2000;
	localparam logic [BRIGHT_W-1:0] FULL_BRIGHT_RST = 8'd30;
	localparam logic [BRIGHT_W-1:0] HALF_BRIGHT_RST = 8'd15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAST_BLINK  = 3'd0,
		REG_STATUS_STEP = 3'd1,
		REG_BUS_TIMEOUT = 3'd2,
		REG_FULL_BRIGHT = 3'd3,
		REG_HALF_BRIGHT = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		COL_OFF    = 3'd0,
		COL_RED    = 3'd1,
		COL_GREEN  = 3'd2,
		COL_PURPLE = 3'd3,
		COL_YELLOW = 3'd4
	} led_color_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] fast_blink_ms;
		logic [PERIOD_W-1:0] status_step_ms;
		logic [PERIOD_W-1:0] bus_timeout_ms;
		logic [BRIGHT_W-1:0] full_brightness;
		logic [BRIGHT_W-1:0] half_brightness;
	} cfg_t;

	typedef struct packed {
		logic                drive;
		led_color_t          color;
		logic [BRIGHT_W-1:0] bright;
	} result_t;

	// colour at a given place of the fault cycle
	function automatic led_color_t fault_color(
		input logic                 fuel,
		input logic                 volt,
		input logic                 no_bus,
		input logic [CYC_POS_W-1:0] idx
	);
		led_color_t           seq [4];
		logic [CYC_POS_W-1:0] n;
		n = '0;
		for (int k = 0; k < 4; k++) begin
			seq[k] = COL_GREEN;
		end
		if (fuel) begin
			seq[n] = COL_PURPLE;
			n = n + 2'd1;
		end
		if (volt) begin
			seq[n] = COL_YELLOW;
			n = n + 2'd1;
		end
		if (no_bus) begin
			seq[n] = COL_RED;
			n = n + 2'd1;
		end
		seq[n] = COL_GREEN;
		return seq[idx];
	endfunction

endpackage

/* rtl/core/slcs_tick.sv */
`timescale 1ns / 1ps

module slcs_tick #(
	parameter int TIME_BITS = slcs_pkg::DEF_TIME_BITS
) (
	input  slcs_pkg::cfg_t                     cfg,
	input  logic [slcs_pkg::IN_TIME_W-1:0]     time_ms,
	input  logic                               signal_lost,
	input  logic                               fuel_fault,
	input  logic                               voltage_fault,
	input  logic [slcs_pkg::TXN_W-1:0]         bus_txn_count,
	input  logic [TIME_BITS-1:0]               last_step_time,
	input  logic [slcs_pkg::TXN_W-1:0]         last_txn_seen,
	input  logic [TIME_BITS-1:0]               last_activity_time,
	input  logic [slcs_pkg::CYC_LEN_W-1:0]     cycle_length,
	input  logic [slcs_pkg::CYC_POS_W-1:0]     cycle_position,
	output logic [TIME_BITS-1:0]               last_step_time_nxt,
	output logic [slcs_pkg::TXN_W-1:0]         last_txn_seen_nxt,
	output logic [TIME_BITS-1:0]               last_activity_time_nxt,
	output logic [slcs_pkg::CYC_LEN_W-1:0]     cycle_length_nxt,
	output logic [slcs_pkg::CYC_POS_W-1:0]     cycle_position_nxt,
	output slcs_pkg::result_t                  result
);

	logic [TIME_BITS+slcs_pkg::IN_TIME_W-1:0] now_ext;
	logic [TIME_BITS-1:0]                     now;
	logic [TIME_BITS-1:0]                     step_elapsed;
	logic [TIME_BITS-1:0]                     act_time;
	logic [TIME_BITS-1:0]                     act_elapsed;
	logic                                     blink_due;
	logic                                     step_due;
	logic                                     no_bus;
	logic [slcs_pkg::CYC_LEN_W-1:0]           len;
	logic [slcs_pkg::CYC_LEN_W-1:0]           pos_inc;
	logic [slcs_pkg::CYC_POS_W-1:0]           pos_step;
	logic [slcs_pkg::CYC_POS_W-1:0]           pos_blink;

	// time brought to the arithmetic width
	assign now_ext = {{TIME_BITS{1'b0}}, time_ms};
	assign now     = now_ext[TIME_BITS-1:0];

	// wrapping elapsed times against the period registers
	assign step_elapsed = now - last_step_time;
	assign blink_due    = step_elapsed >= TIME_BITS'(cfg.fast_blink_ms);
	assign step_due     = step_elapsed >= TIME_BITS'(cfg.status_step_ms);

	// bus activity tracking
	assign act_time    = (bus_txn_count != last_txn_seen) ? now : last_activity_time;
	assign act_elapsed = now - act_time;
	assign no_bus      = act_elapsed >= TIME_BITS'(cfg.bus_timeout_ms);

	// fault cycle length and next position
	assign len = slcs_pkg::CYC_LEN_W'(fuel_fault) + slcs_pkg::CYC_LEN_W'(voltage_fault)
		+ slcs_pkg::CYC_LEN_W'(no_bus) + 3'd1;
	assign pos_inc   = {1'b0, cycle_position} + 3'd1;
	assign pos_step  = (pos_inc >= cycle_length) ? '0 : pos_inc[slcs_pkg::CYC_POS_W-1:0];
	assign pos_blink = (cycle_position == '0) ? 2'd1 : 2'd0;

	// next state and result for one item
	always_comb begin
		last_step_time_nxt     = last_step_time;
		last_txn_seen_nxt      = last_txn_seen;
		last_activity_time_nxt = last_activity_time;
		cycle_length_nxt       = cycle_length;
		cycle_position_nxt     = cycle_position;
		result.drive           = 1'b0;
		result.color           = slcs_pkg::COL_OFF;
		result.bright          = '0;
		if (signal_lost) begin
			if (blink_due) begin
				last_step_time_nxt = now;
				cycle_position_nxt = pos_blink;
				result.drive       = 1'b1;
				result.color       = (pos_blink != '0) ? slcs_pkg::COL_RED : slcs_pkg::COL_OFF;
				result.bright      = cfg.full_brightness;
			end
		end else begin
			last_txn_seen_nxt      = bus_txn_count;
			last_activity_time_nxt = act_time;
			if (!no_bus && !fuel_fault && !voltage_fault) begin
				cycle_length_nxt = '0;
				result.drive     = 1'b1;
				result.color     = slcs_pkg::COL_GREEN;
				result.bright    = cfg.half_brightness;
			end else if (len != cycle_length) begin
				cycle_length_nxt   = len;
				cycle_position_nxt = '0;
				last_step_time_nxt = now;
				result.drive       = 1'b1;
				result.color       = slcs_pkg::fault_color(fuel_fault, voltage_fault,
					no_bus, 2'd0);
				result.bright      = cfg.full_brightness;
			end else if (step_due) begin
				last_step_time_nxt = now;
				cycle_position_nxt = pos_step;
				result.drive       = 1'b1;
				result.color       = slcs_pkg::fault_color(fuel_fault, voltage_fault,
					no_bus, pos_step);
				result.bright      = cfg.full_brightness;
			end
		end
	end

endmodule

/* rtl/core/status_led_color_sequencer.sv */
`timescale 1ns / 1ps
// an accepted item passes through the input register, then the result register; a
// stall on the result side holds it in the input register; throughput: one item per
// cycle while out_ready holds, the sequencer state loop closes through the tick logic combinationally
// reset: registers return to 125/500/2000/30/15, all sequencer state clears to zero,
// both stages empty
module status_led_color_sequencer #(
	parameter int TIME_BITS = slcs_pkg::DEF_TIME_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [slcs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [slcs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [slcs_pkg::IN_TIME_W-1:0]      time_ms,
	input  logic                                signal_lost,
	input  logic                                fuel_fault,
	input  logic                                voltage_fault,
	input  logic [slcs_pkg::TXN_W-1:0]          bus_txn_count,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                drive_update,
	output logic [2:0]                          led_color,
	output logic [slcs_pkg::BRIGHT_W-1:0]       led_brightness
);

	slcs_pkg::cfg_t                    cfg_q;
	logic                              valid_s1;
	logic [slcs_pkg::IN_TIME_W-1:0]    time_s1;
	logic                              lost_s1;
	logic                              fuel_s1;
	logic                              volt_s1;
	logic [slcs_pkg::TXN_W-1:0]        txn_s1;
	logic [TIME_BITS-1:0]              last_step_time_q;
	logic [slcs_pkg::TXN_W-1:0]        last_txn_seen_q;
	logic [TIME_BITS-1:0]              last_activity_time_q;
	logic [slcs_pkg::CYC_LEN_W-1:0]    cycle_length_q;
	logic [slcs_pkg::CYC_POS_W-1:0]    cycle_position_q;
	logic [TIME_BITS-1:0]              last_step_time_nxt;
	logic [slcs_pkg::TXN_W-1:0]        last_txn_seen_nxt;
	logic [TIME_BITS-1:0]              last_activity_time_nxt;
	logic [slcs_pkg::CYC_LEN_W-1:0]    cycle_length_nxt;
	logic [slcs_pkg::CYC_POS_W-1:0]    cycle_position_nxt;
	slcs_pkg::result_t                 result;
	slcs_pkg::result_t                 result_q;
	logic                              out_valid_q;
	logic                              advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fast_blink_ms   <= slcs_pkg::FAST_BLINK_RST;
			cfg_q.status_step_ms  <= slcs_pkg::STATUS_STEP_RST;
			cfg_q.bus_timeout_ms  <= slcs_pkg::BUS_TIMEOUT_RST;
			cfg_q.full_brightness <= slcs_pkg::FULL_BRIGHT_RST;
			cfg_q.half_brightness <= slcs_pkg::HALF_BRIGHT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				slcs_pkg::REG_FAST_BLINK:  cfg_q.fast_blink_ms   <= cfg_wdata;
				slcs_pkg::REG_STATUS_STEP: cfg_q.status_step_ms  <= cfg_wdata;
				slcs_pkg::REG_BUS_TIMEOUT: cfg_q.bus_timeout_ms  <= cfg_wdata;
				slcs_pkg::REG_FULL_BRIGHT: cfg_q.full_brightness <= cfg_wdata[slcs_pkg::BRIGHT_W-1:0];
				slcs_pkg::REG_HALF_BRIGHT: cfg_q.half_brightness <= cfg_wdata[slcs_pkg::BRIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: the input stage moves on whenever the result register is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			time_s1 <= time_ms;
			lost_s1 <= signal_lost;
			fuel_s1 <= fuel_fault;
			volt_s1 <= voltage_fault;
			txn_s1  <= bus_txn_count;
		end
	end

	// per-item colour logic
	slcs_tick #(
		.TIME_BITS(TIME_BITS)
	) u_tick (
		.cfg                    (cfg_q),
		.time_ms                (time_s1),
		.signal_lost            (lost_s1),
		.fuel_fault             (fuel_s1),
		.voltage_fault          (volt_s1),
		.bus_txn_count          (txn_s1),
		.last_step_time         (last_step_time_q),
		.last_txn_seen          (last_txn_seen_q),
		.last_activity_time     (last_activity_time_q),
		.cycle_length           (cycle_length_q),
		.cycle_position         (cycle_position_q),
		.last_step_time_nxt     (last_step_time_nxt),
		.last_txn_seen_nxt      (last_txn_seen_nxt),
		.last_activity_time_nxt (last_activity_time_nxt),
		.cycle_length_nxt       (cycle_length_nxt),
		.cycle_position_nxt     (cycle_position_nxt),
		.result                 (result)
	);

	// sequencer state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_step_time_q     <= '0;
			last_txn_seen_q      <= '0;
			last_activity_time_q <= '0;
			cycle_length_q       <= '0;
			cycle_position_q     <= '0;
		end else if (advance) begin
			last_step_time_q     <= last_step_time_nxt;
			last_txn_seen_q      <= last_txn_seen_nxt;
			last_activity_time_q <= last_activity_time_nxt;
			cycle_length_q       <= cycle_length_nxt;
			cycle_position_q     <= cycle_position_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign drive_update   = result_q.drive;
	assign led_color      = result_q.color;
	assign led_brightness = result_q.bright;

	// an undriven tick shows nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_q.drive) |->
		(result_q.color == slcs_pkg::COL_OFF && result_q.bright == '0))
		else $error("undriven result carries colour or brightness");

	// fault cycle never longer than three faults plus green
	assert property (@(posedge clk) disable iff (!arst_n)
		cycle_length_q <= 3'd4)
		else $error("fault cycle length out of range");

	// a held input item keeps its payload while the result side stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(time_s1) && $stable(txn_s1)))
		else $error("input stage lost or changed a stalled item");

	// state only moves when an item is processed
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(cycle_length_q) && $stable(cycle_position_q)))
		else $error("sequencer state changed without an item");

endmodule
